// File: hdl/tar_archive_stream_walker_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tar archive stream walker
// Clocked on clk, held off while arst_n is low. Define ASSERT_OFF to strip.
// ----------------------------------------------------------------------------
`ifndef TAR_ARCHIVE_STREAM_WALKER_TOP_DEFINES_SVH
`define TAR_ARCHIVE_STREAM_WALKER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication: cond |-> prop.
`define TASW_ASSERT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);
// Next-cycle implication: cond |=> prop.
`define TASW_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define TASW_ASSERT(lbl, cond, prop, msg)
`define TASW_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

// File: hdl/tasw_pkg.sv
// ----------------------------------------------------------------------------
// tasw_pkg
// Shared types and constants of the tar archive stream walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tasw_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int POS_W       = $clog2(BLOCK_BYTES);
	localparam int LEN_W       = 33;
	localparam int MEMBER_W    = 16;
	localparam int SIZE_DIGITS = 11;

	localparam logic [POS_W-1:0] BLOCK_LAST = POS_W'(BLOCK_BYTES - 1);
	localparam logic [POS_W-1:0] SIZE_FIRST = POS_W'(124);
	localparam logic [POS_W-1:0] SIZE_STOP  = POS_W'(124 + SIZE_DIGITS);
	localparam logic [POS_W-1:0] SIZE_LAST  = POS_W'(124 + SIZE_DIGITS - 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [MEMBER_W-1:0] MEMBER_MAX = {MEMBER_W{1'b1}};

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_CONTENT = 2'd1,
		PH_PADDING = 2'd2,
		PH_TRAILER = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t              kind;
		logic [MEMBER_W-1:0] number;
		logic [POS_W-1:0]    offset;
		logic [LEN_W-1:0]    length;
		logic                length_valid;
		logic                last;
	} tasw_result_t;

endpackage

`default_nettype wire

// File: hdl/tasw_walker.sv
// ----------------------------------------------------------------------------
// tasw_walker
// Archive walk state and the per-beat labelling logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tar_archive_stream_walker_top_defines.svh"

module tasw_walker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step_en,
	input  wire logic [7:0]           step_byte,
	output tasw_pkg::tasw_result_t    result
);
	import tasw_pkg::*;

	phase_t              phase_q, phase_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [LEN_W-1:0]    acc_q, acc_d, acc_v, acc_fold;
	logic                stop_q, stop_d, stop_v;
	logic [LEN_W-1:0]    rem_q, rem_d, rem_dec;
	logic [MEMBER_W-1:0] member_q, member_d;
	logic                empty_q, empty_d, empty_v;
	logic                block_end, in_field, count_en;

	assign block_end = (pos_q == BLOCK_LAST);
	assign in_field  = (pos_q >= SIZE_FIRST) && (pos_q < SIZE_STOP);
	assign rem_dec   = rem_q - LEN_W'(1);
	assign pos_d     = block_end ? '0 : pos_q + POS_W'(1);

	always_comb begin
		// clear the size parse at the first byte of a header
		acc_v   = (pos_q == '0) ? '0 : acc_q;
		stop_v  = (pos_q == '0) ? 1'b0 : stop_q;
		empty_v = (pos_q == '0) ? (step_byte == CH_NUL) : empty_q;
		acc_fold = {acc_v[LEN_W-4:0], 3'b000} + {{(LEN_W-8){1'b0}}, step_byte}
			- {{(LEN_W-8){1'b0}}, CH_ZERO};
	end

	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		stop_d   = stop_q;
		rem_d    = rem_q;
		empty_d  = empty_q;
		count_en = 1'b0;

		result.kind         = phase_q;
		result.number       = member_q;
		result.offset       = pos_q;
		result.length       = acc_q;
		result.length_valid = 1'b1;
		result.last         = 1'b0;

		unique case (phase_q)
			PH_HEADER: begin
				acc_d   = acc_v;
				stop_d  = stop_v;
				empty_d = empty_v;
				if (in_field && !stop_v) begin
					if (step_byte == CH_NUL || step_byte == CH_SPACE) begin
						stop_d = 1'b1;
					end else begin
						acc_d = acc_fold;
					end
				end
				result.length       = acc_d;
				result.length_valid = stop_d || (pos_q >= SIZE_LAST);
				if (block_end) begin
					if (empty_v) begin
						phase_d = PH_TRAILER;
					end else if (acc_d != '0) begin
						rem_d   = acc_d;
						phase_d = PH_CONTENT;
					end else begin
						result.last = 1'b1;
						count_en    = 1'b1;
					end
				end
			end
			PH_CONTENT: begin
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					if (block_end) begin
						result.last = 1'b1;
						count_en    = 1'b1;
						phase_d     = PH_HEADER;
					end else begin
						phase_d = PH_PADDING;
					end
				end
			end
			PH_PADDING: begin
				if (block_end) begin
					result.last = 1'b1;
					count_en    = 1'b1;
					phase_d     = PH_HEADER;
				end
			end
			PH_TRAILER: begin
				result.length       = '0;
				result.length_valid = 1'b0;
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase

		member_d = (count_en && member_q != MEMBER_MAX) ? member_q + MEMBER_W'(1) : member_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			acc_q    <= '0;
			stop_q   <= 1'b0;
			rem_q    <= '0;
			member_q <= '0;
			empty_q  <= 1'b0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			acc_q    <= acc_d;
			stop_q   <= stop_d;
			rem_q    <= rem_d;
			member_q <= member_d;
			empty_q  <= empty_d;
		end
	end

	// content phase always has bytes left to count
	`TASW_ASSERT(a_content_left, phase_q == PH_CONTENT, rem_q != '0, "content with zero remaining")
	// padding never starts on a block boundary
	`TASW_ASSERT(a_pad_offset, phase_q == PH_PADDING, pos_q != '0, "padding at block start")
	// trailer is final
	`TASW_ASSERT_NEXT(a_trailer_sticky, phase_q == PH_TRAILER, phase_q == PH_TRAILER,
		"left trailer phase")

endmodule

`default_nettype wire

// File: hdl/tar_archive_stream_walker_top.sv
// ----------------------------------------------------------------------------
// tar_archive_stream_walker_top
// A result beat passes from the input register to the result register after
// its input beat is accepted; a full result register can hold it back.
// Throughput: one archive byte per cycle while m_tready is held high.
// Input and result registers form a two-stage pipe; while a result waits, one
// further beat is taken into the input register and then input stalls. Reset
// (arst_n low) empties both stages and restarts the walk in header phase at
// block offset zero with a member count of zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tar_archive_stream_walker_top_defines.svh"

module tar_archive_stream_walker_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// archive byte stream in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] archive_byte
	// labelled byte stream out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // [7:0] byte_echo, [23:8] member_number,
	                                    // [32:24] offset_in_block, [65:33] member_length,
	                                    // [66] length_valid, [71:67] zero
	output logic [1:0]       m_tuser,   // [1:0] byte_kind
	output logic             m_tlast    // member_last
);
	import tasw_pkg::*;

	// stage 1: accepted byte
	logic         valid_s1;
	logic [7:0]   byte_s1;
	// stage 2: result beat
	logic         valid_s2;
	logic [7:0]   byte_s2;
	tasw_result_t result_s2;

	tasw_result_t step_result;
	logic         s2_free;
	logic         advance;

	// advance stage 1 into the result register when it is empty or being drained
	assign s2_free  = !valid_s2 || m_tready;
	assign advance  = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers: hold while stalled, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			byte_s2   <= byte_s1;
			result_s2 <= step_result;
		end
	end

	// walk state advances exactly once per beat handed to the result stage
	tasw_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.step_byte (byte_s1),
		.result    (step_result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b00000, result_s2.length_valid, result_s2.length,
		result_s2.offset, result_s2.number, byte_s2};
	assign m_tuser  = result_s2.kind;
	assign m_tlast  = result_s2.last;

	// trailer beats carry no length and never close a member
	`TASW_ASSERT(a_trailer_clean, valid_s2 && result_s2.kind == PH_TRAILER,
		!result_s2.length_valid && !result_s2.last && result_s2.length == '0,
		"trailer beat carries member data")
	// content beats belong to a member with a nonzero size
	`TASW_ASSERT(a_content_len, valid_s2 && result_s2.kind == PH_CONTENT,
		result_s2.length != '0 && result_s2.length_valid, "content beat without size")
	// a padding beat closes the member only on the last byte of the block
	`TASW_ASSERT(a_pad_last, valid_s2 && result_s2.kind == PH_PADDING,
		result_s2.last == (result_s2.offset == BLOCK_LAST), "padding last misplaced")

endmodule

`default_nettype wire

// File: verif/tasw_label_checker.sv
// ----------------------------------------------------------------------------
// tasw_label_checker
// Watches both streams of the tar archive stream walker, labels every accepted
// archive byte with its own copy of the walk and compares each result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tasw_label_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] archive_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,   // [7:0] byte_echo, [23:8] member_number,
	                               // [32:24] offset_in_block, [65:33] member_length,
	                               // [66] length_valid, [71:67] zero
	input  logic [1:0]  m_tuser,   // [1:0] byte_kind
	input  logic        m_tlast,   // member_last
	output int          mismatches,
	output int          outstanding
);
	import tasw_pkg::*;

	typedef struct packed {
		logic [7:0]   echo;
		tasw_result_t label;
	} labelled_byte_t;

	labelled_byte_t expected_labels[$];

	// walk state
	phase_t              walk_phase;
	logic [POS_W-1:0]    walk_pos;
	logic [LEN_W-1:0]    size_acc;
	logic                size_stopped;
	logic [LEN_W-1:0]    content_left;
	logic [MEMBER_W-1:0] member_count;
	logic                name_empty;

	int fail_count = 0;
	int beat_count = 0;

	assign mismatches = fail_count;

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t beat %0d: %s is %0h, expected %0h", $time, beat_count, field, got, want);
		fail_count++;
	endtask

	// Advance the walk by one archive byte and label it.
	task automatic label_byte(input logic [7:0] b, output labelled_byte_t lb);
		logic block_end;
		logic closes;
		block_end = (walk_pos == BLOCK_LAST);
		closes = 1'b0;
		lb.echo = b;
		lb.label.kind = walk_phase;
		lb.label.number = member_count;
		lb.label.offset = walk_pos;
		lb.label.length = size_acc;
		lb.label.length_valid = 1'b1;
		lb.label.last = 1'b0;
		case (walk_phase)
			PH_HEADER: begin
				if (walk_pos == '0) begin
					size_acc = '0;
					size_stopped = 1'b0;
					name_empty = (b == CH_NUL);
				end
				if (walk_pos >= SIZE_FIRST && walk_pos < SIZE_STOP && !size_stopped) begin
					if (b == CH_NUL || b == CH_SPACE)
						size_stopped = 1'b1;
					else
						size_acc = (size_acc << 3) + LEN_W'(b) - LEN_W'(CH_ZERO);
				end
				lb.label.length = size_acc;
				lb.label.length_valid = size_stopped || (walk_pos >= SIZE_LAST);
				if (block_end) begin
					if (name_empty) begin
						walk_phase = PH_TRAILER;
					end else if (size_acc != '0) begin
						content_left = size_acc;
						walk_phase = PH_CONTENT;
					end else begin
						closes = 1'b1;
					end
				end
			end
			PH_CONTENT: begin
				content_left = content_left - 1'b1;
				if (content_left == '0) begin
					if (block_end) begin
						closes = 1'b1;
						walk_phase = PH_HEADER;
					end else begin
						walk_phase = PH_PADDING;
					end
				end
			end
			PH_PADDING: begin
				if (block_end) begin
					closes = 1'b1;
					walk_phase = PH_HEADER;
				end
			end
			default: begin
				lb.label.length = '0;
				lb.label.length_valid = 1'b0;
			end
		endcase
		if (closes) begin
			lb.label.last = 1'b1;
			if (member_count != MEMBER_MAX)
				member_count = member_count + 1'b1;
		end
		walk_pos = block_end ? '0 : walk_pos + 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		labelled_byte_t fresh;
		labelled_byte_t oldest;
		if (!arst_n) begin
			walk_phase = PH_HEADER;
			walk_pos = '0;
			size_acc = '0;
			size_stopped = 1'b0;
			content_left = '0;
			member_count = '0;
			name_empty = 1'b0;
			expected_labels.delete();
			outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				label_byte(s_tdata, fresh);
				expected_labels.push_back(fresh);
			end
			if (m_tvalid && m_tready) begin
				if (expected_labels.size() == 0) begin
					report_mismatch("beat with nothing pending, byte", m_tdata[7:0], 0);
				end else begin
					oldest = expected_labels.pop_front();
					if (m_tdata[7:0] !== oldest.echo)
						report_mismatch("byte_echo", m_tdata[7:0], oldest.echo);
					if (m_tuser !== oldest.label.kind)
						report_mismatch("byte_kind", m_tuser, oldest.label.kind);
					if (m_tdata[23:8] !== oldest.label.number)
						report_mismatch("member_number", m_tdata[23:8], oldest.label.number);
					if (m_tdata[32:24] !== oldest.label.offset)
						report_mismatch("offset_in_block", m_tdata[32:24], oldest.label.offset);
					if (m_tdata[65:33] !== oldest.label.length)
						report_mismatch("member_length", m_tdata[65:33], oldest.label.length);
					if (m_tdata[66] !== oldest.label.length_valid)
						report_mismatch("length_valid", m_tdata[66], oldest.label.length_valid);
					if (m_tlast !== oldest.label.last)
						report_mismatch("member_last", m_tlast, oldest.label.last);
					if (m_tdata[71:67] !== 5'd0)
						report_mismatch("tdata fill", m_tdata[71:67], 0);
				end
				beat_count++;
			end
			outstanding <= expected_labels.size();
		end
	end

endmodule

// File: verif/tb_tar_archive_stream_walker_top.sv
// ----------------------------------------------------------------------------
// tb_tar_archive_stream_walker_top
// Feeds one tar member of two blocks through the walker: a header whose size
// field is written in a random style, a short run of content and padding to
// the block boundary. The checker beside the block labels every byte itself
// and compares each result beat; this module only makes stimulus, shapes the
// flow on both sides and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tar_archive_stream_walker_top;

	import tasw_pkg::*;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 9;
	localparam int LONG_HOLD      = 500;
	localparam int END_SETTLE     = 10;

	// keep content short: a member never carries more than this many bytes
	localparam logic [LEN_W-1:0] SIZE_CAP = LEN_W'(400);
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// ways of writing the octal size field of a header
	typedef enum int {
		SZ_FULL,     // all eleven digits, no stop character
		SZ_NUL,      // some digits, then NUL
		SZ_SPACE,    // some digits, then space
		SZ_BLANK,    // stop character in the first slot: size zero
		SZ_GARBAGE,  // characters, octal or not, folded in as they are
		SZ_WRAP      // characters that wrap the sum round 2^33 back to small
	} size_style_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] archive_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;           // [7:0] byte_echo, [23:8] member_number,
	                                // [32:24] offset_in_block, [65:33] member_length,
	                                // [66] length_valid, [71:67] zero
	logic [1:0]  m_tuser;           // [1:0] byte_kind
	logic        m_tlast;           // member_last

	int mismatches;
	int outstanding;

	// sender flow shaping
	int burst_left = 0;
	int gap_left = 0;

	logic [7:0] header_block [BLOCK_BYTES];

	always #CLK_HALF clk = ~clk;

	tar_archive_stream_walker_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	tasw_label_checker label_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Offer one archive byte and hold it until the beat is taken. Bursts of
	// random length are separated by random gaps; some bursts are long and
	// some gaps are empty, so stretches run with no idling at all.
	task automatic send_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
			                                         : $urandom_range(1, 48);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
		end
		if (gap_left > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		// values read just after the edge are the ones the edge sampled
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// Drop valid and hold off until every labelled byte has come back.
	task automatic drain_pause();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		burst_left = 0;
	endtask

	// Fold the size field of the header being built, as the walker reads it;
	// the stimulus needs it to know how much content follows.
	function automatic logic [LEN_W-1:0] folded_size();
		logic [LEN_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < SIZE_DIGITS; i++) begin
			if (header_block[SIZE_FIRST + i] == CH_NUL ||
			    header_block[SIZE_FIRST + i] == CH_SPACE)
				break;
			acc = (acc << 3) + LEN_W'(header_block[SIZE_FIRST + i]) - LEN_W'(CH_ZERO);
		end
		return acc;
	endfunction

	// Write the size field in the given style; slots after a stop character
	// keep their random filler, which the walker must ignore.
	task automatic fill_size_field(input size_style_t style, input logic [LEN_W-1:0] value);
		logic [7:0] digits [SIZE_DIGITS];
		int sig;
		int len;
		for (int k = 0; k < SIZE_DIGITS; k++)
			digits[k] = CH_ZERO + 8'((value >> (3 * (SIZE_DIGITS - 1 - k))) & 7);
		sig = 1;
		while (sig < SIZE_DIGITS && (value >> (3 * sig)) != 0)
			sig++;
		case (style)
			SZ_FULL: begin
				for (int k = 0; k < SIZE_DIGITS; k++)
					header_block[SIZE_FIRST + k] = digits[k];
			end
			SZ_NUL, SZ_SPACE: begin
				// leading zeros vary, so the stop lands anywhere after the significant digits
				len = $urandom_range(sig, SIZE_DIGITS - 1);
				for (int k = 0; k < len; k++)
					header_block[SIZE_FIRST + k] = digits[SIZE_DIGITS - len + k];
				header_block[SIZE_FIRST + len] = (style == SZ_NUL) ? CH_NUL : CH_SPACE;
			end
			SZ_BLANK: begin
				header_block[SIZE_FIRST] = $urandom_range(0, 1) ? CH_SPACE : CH_NUL;
			end
			SZ_GARBAGE: begin
				header_block[SIZE_FIRST] = 8'($urandom_range(48, 255));
				len = $urandom_range(1, 2);
				if (len == 2)
					header_block[SIZE_FIRST + 1] = 8'($urandom_range(33, 255));
				header_block[SIZE_FIRST + len] = $urandom_range(0, 1) ? CH_SPACE : CH_NUL;
			end
			default: begin
				// '/' folds to all ones; the next digit of eight or more
				// carries the sum round past zero
				header_block[SIZE_FIRST] = CH_SLASH;
				header_block[SIZE_FIRST + 1] = 8'($urandom_range(56, 80));
				header_block[SIZE_FIRST + 2] = CH_NUL;
			end
		endcase
	endtask

	// Send one member: header, content and padding to the block boundary.
	task automatic send_member(input size_style_t style, input logic [LEN_W-1:0] value,
			input bit dirty_pad);
		logic [LEN_W-1:0] size;
		int pad;
		header_block[0] = 8'($urandom_range(1, 255));
		for (int i = 1; i < BLOCK_BYTES; i++)
			header_block[i] = 8'($urandom_range(0, 255));
		fill_size_field(style, value);
		size = folded_size();
		if (size == '0 || size > SIZE_CAP) begin
			// a field that folded to nothing or to something huge: rewrite it plainly
			fill_size_field(SZ_NUL, value % SIZE_CAP);
			size = folded_size();
		end
		for (int i = 0; i < BLOCK_BYTES; i++)
			send_byte(header_block[i]);
		// let the pipe empty between header and content
		drain_pause();
		for (int n = 0; n < int'(size); n++)
			send_byte(8'($urandom_range(0, 255)));
		pad = (size == '0) ? 0 : (BLOCK_BYTES - int'(size % BLOCK_BYTES)) % BLOCK_BYTES;
		// padding is not checked by the walker, so sometimes fill it with noise
		for (int n = 0; n < pad; n++)
			send_byte(dirty_pad ? 8'($urandom_range(0, 255)) : 8'h00);
	endtask

	// Receiver: a ready pattern whose mode is drawn anew from four, plus two
	// long hold-offs counted here so that the block fills up and stalls its
	// input while the sender keeps offering bytes.
	initial begin
		int cycles;
		int mode;
		logic [7:0] mask;
		cycles = 0;
		mode = 0;
		mask = 8'hFF;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles == 100 || cycles == 800) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				cycles += LONG_HOLD;
			end else begin
				if (cycles % 64 == 0) begin
					mode = $urandom_range(0, 3);
					mask = 8'($urandom_range(1, 255));
				end
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= mask[cycles % 8];
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Give up after a generous fixed time.
	initial begin
		#2_000_000;
		$display("tar_archive_stream_walker_top test failed");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		logic [LEN_W-1:0] value;
		bit dirty;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// One member of two blocks: the size field in a random style, a short
		// run of content and padding that is either clean or noisy.
		value = LEN_W'($urandom_range(1, int'(SIZE_CAP) - 1));
		dirty = ($urandom_range(0, 1) == 0);
		send_member(size_style_t'($urandom_range(SZ_FULL, SZ_WRAP)), value, dirty);

		// drop valid, wait for the last labels, then let the pipe settle
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (END_SETTLE) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("tar_archive_stream_walker_top test passed");
		end else begin
			$display("tar_archive_stream_walker_top test failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/tasw_pkg.sv
hdl/tasw_walker.sv
hdl/tar_archive_stream_walker_top.sv
verif/tasw_label_checker.sv
verif/tb_tar_archive_stream_walker_top.sv
